### design/lhm_pkg.sv
`default_nettype none
package lhm_pkg;

  localparam int GROUPS_DEF = 3;
  localparam int KINDS_DEF  = 3;

  localparam int DELAY_W = 48;
  localparam int CNT_W   = 32;
  localparam int SUM_W   = 40;
  localparam int MAX_W   = 28;
  localparam int THR_W   = 28;
  // The us value is only summed for delays under 1 ms, so it stays below 1000.
  localparam int US_W    = 10;
  localparam int MS_W    = 29;
  localparam int DIVD_W  = 48;
  localparam int DIVS_W  = 35;
  localparam int NBUCKETS = 5;
  localparam int NEVENTS  = 4;

  // Reciprocal conversion: ms = ((delay >> 6) * MS_RECIP) >> 56 and, for delays
  // under 1 ms, us = ((delay >> 3) * US_RECIP) >> 24. Both are exact over the range.
  localparam int ACC_W  = 85;
  localparam int HALF_W = 22;
  localparam logic [17:0] US_RECIP = 18'd134218;
  localparam logic [42:0] MS_RECIP = 43'd4611686018428;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_EVENT  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] EV_KSWAPD    = 2'd0;
  localparam logic [1:0] EV_COMPACT   = 2'd1;
  localparam logic [1:0] EV_PAGEALLOC = 2'd2;
  localparam logic [1:0] EV_SLOWPATH  = 2'd3;

  localparam logic [1:0] CFG_LOW_MS    = 2'd0;
  localparam logic [1:0] CFG_NORMAL_MS = 2'd1;
  localparam logic [1:0] CFG_HIGH_MS   = 2'd2;
  localparam logic [1:0] CFG_ENABLE    = 2'd3;

  localparam logic [2:0] B_MIN   = 3'd0;
  localparam logic [2:0] B_LOW   = 3'd1;
  localparam logic [2:0] B_MID   = 3'd2;
  localparam logic [2:0] B_HIGH  = 3'd3;
  localparam logic [2:0] B_FATAL = 3'd4;

  localparam logic [1:0] SLOWPATH_KIND = 2'd2;

  typedef struct packed {
    logic [NBUCKETS-1:0][CNT_W-1:0] cnt;
    logic [SUM_W-1:0]               sum_ms;
    logic [SUM_W-1:0]               sum_us;
    logic [MAX_W-1:0]               max_ms;
  } entry_t;

endpackage
`default_nettype wire

### design/lhm_ram.sv
`default_nettype none
module lhm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### design/lhm_div.sv
`default_nettype none
module lhm_div #(
  parameter int DW = 48,
  parameter int VW = 35
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [VW-1:0] dsr;
  logic [DW-1:0] q;
  logic [CW-1:0] cnt;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fits;

  // One restoring step per cycle, quotient bits shift in at the bottom.
  assign trial = {rem, q[DW-1]};
  assign diff  = trial - {1'b0, dsr};
  assign fits  = trial >= {1'b0, dsr};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[VW-1:0] : trial[VW-1:0];
      q   <= {q[DW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

### design/latency_histogram_monitor_unit.sv
`default_nettype none
// Latency histogram monitor. One table entry per (group, kind) pair holds five
// bucket counts, a ms sum, a us sum and a ms maximum, all in one synchronous RAM;
// four event counters (kswapd, compaction, page allocation, slowpath) sit in flops.
// Commands are taken one at a time: a record reads its entry, converts the delay
// to ms by reciprocal multiplication built from four partial products (the us
// value of a sub-millisecond delay comes from one small multiply), and writes the
// updated entry back before the next command is taken. A read fetches the entry
// and runs the shared radix-2 divider once for each of the two averages whose
// divisor is nonzero; the result beat then waits in an output register while the
// next command is already taken. Event and clear commands finish in the cycle
// they are accepted.
// Clear drops a valid bit per entry, so the RAM needs no clearing pass after reset;
// an entry without its valid bit reads as all zero. Configuration writes are taken
// at any time, but are meant to be issued only while the block is idle.
module latency_histogram_monitor_unit #(
  parameter int GROUPS = lhm_pkg::GROUPS_DEF,
  parameter int KINDS  = lhm_pkg::KINDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [lhm_pkg::THR_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  command,
  input  logic [1:0]                  group_index,
  input  logic [1:0]                  kind_index,
  input  logic [lhm_pkg::DELAY_W-1:0] delay_ns,
  input  logic [1:0]                  event_kind,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lhm_pkg::CNT_W-1:0]   min_count,
  output logic [lhm_pkg::CNT_W-1:0]   low_count,
  output logic [lhm_pkg::CNT_W-1:0]   mid_count,
  output logic [lhm_pkg::CNT_W-1:0]   high_count,
  output logic [lhm_pkg::CNT_W-1:0]   fatal_count,
  output logic [lhm_pkg::SUM_W-1:0]   avg_ms,
  output logic [lhm_pkg::SUM_W-1:0]   avg_us,
  output logic [lhm_pkg::MAX_W-1:0]   max_ms,
  output logic [lhm_pkg::CNT_W-1:0]   kswapd_count,
  output logic [lhm_pkg::CNT_W-1:0]   compaction_count,
  output logic [lhm_pkg::CNT_W-1:0]   page_alloc_count,
  output logic [lhm_pkg::CNT_W-1:0]   slowpath_count
);
  import lhm_pkg::*;

  localparam int ENTRIES = GROUPS * KINDS;
  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CONV   = 4'd1;
  localparam logic [3:0] S_WR     = 4'd3;
  localparam logic [3:0] S_RD     = 4'd4;
  localparam logic [3:0] S_AMS_GO = 4'd5;
  localparam logic [3:0] S_AMS    = 4'd6;
  localparam logic [3:0] S_AUS_GO = 4'd7;
  localparam logic [3:0] S_AUS    = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  // Configuration registers.
  logic [THR_W-1:0] low_thr;
  logic [THR_W-1:0] normal_thr;
  logic [THR_W-1:0] high_thr;
  logic             enable;

  logic [3:0]   state;
  logic [3:0]   state_next;
  logic [ENTRIES-1:0] vld;
  logic [NEVENTS-1:0][CNT_W-1:0] evc;

  logic [EW-1:0]  ent_idx;
  logic           rd_ok;
  logic           slow;
  logic [US_W-1:0] us_val;
  logic [MS_W-1:0] ms_val;
  entry_t         ent;
  logic [CNT_W+1:0] upper;
  logic [CNT_W+2:0] allc;
  logic [SUM_W-1:0] avg_ms_v;

  // Delay conversion.
  logic [DELAY_W-1:0]  dly;
  logic [2:0]          step;
  logic [HALF_W-1:0]   mul_a;
  logic [HALF_W-1:0]   mul_b;
  logic [2*HALF_W-1:0] mul_p;
  logic [ACC_W-1:0]    pp_next;
  logic [ACC_W-1:0]    pp;
  logic [ACC_W-1:0]    acc;
  logic [34:0]         us_prod;

  logic          in_fire;
  logic          cfg_fire;
  logic          idx_ok;
  logic [EW-1:0] in_e;
  logic          rec_go;
  logic          out_load;
  logic          clear_fire;

  entry_t      ram_rdata;
  entry_t      entry_cur;
  entry_t      upd;
  logic        ram_re;
  logic        ram_we;

  logic              div_start;
  logic [DIVD_W-1:0] div_dividend;
  logic [DIVS_W-1:0] div_divisor;
  logic              div_busy;
  logic              div_done;
  logic [DIVD_W-1:0] div_q;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;

  // Entry index; out-of-range pairs never touch the table.
  assign idx_ok = (int'(group_index) < GROUPS) && (int'(kind_index) < KINDS);
  assign in_e   = EW'(EW'(group_index) * EW'(KINDS) + EW'(kind_index));
  assign rec_go = in_fire && (command == CMD_RECORD) && enable && idx_ok;
  assign clear_fire = in_fire && (command == CMD_CLEAR);

  assign ram_re = rec_go || (in_fire && (command == CMD_READ) && idx_ok);
  assign ram_we = (state == S_WR);

  // The RAM output holds between reads, so it stays usable for the whole command.
  assign entry_cur = rd_ok ? ram_rdata : '0;

  lhm_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ent_idx),
    .wdata(upd),
    .re   (ram_re),
    .raddr(in_e),
    .rdata(ram_rdata)
  );

  lhm_div #(
    .DW(DIVD_W),
    .VW(DIVS_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_q)
  );

  // Partial products of (delay >> 6) * MS_RECIP, one per conversion step. The
  // low and high halves of the shifted delay are 21 bits, those of the constant
  // 22 and 21 bits.
  always_comb begin
    mul_a = {1'b0, dly[26:6]};
    mul_b = MS_RECIP[HALF_W-1:0];
    case (step)
      3'd1: mul_b = {1'b0, MS_RECIP[42:HALF_W]};
      3'd2: mul_a = {1'b0, dly[47:27]};
      3'd3: begin
        mul_a = {1'b0, dly[47:27]};
        mul_b = {1'b0, MS_RECIP[42:HALF_W]};
      end
      default: begin
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    case (step)
      3'd1:    pp_next = ACC_W'(mul_p) << 22;
      3'd2:    pp_next = ACC_W'(mul_p) << 21;
      3'd3:    pp_next = ACC_W'(mul_p) << 43;
      default: pp_next = ACC_W'(mul_p);
    endcase
  end

  assign us_prod = 35'(dly[19:3]) * 35'(US_RECIP);
  assign ms_val  = acc[ACC_W-1:ACC_W-MS_W];

  // The divider serves the two averages of a read.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state)
      S_AMS_GO: begin
        div_start    = (upper != '0);
        div_dividend = DIVD_W'(ent.sum_ms);
        div_divisor  = DIVS_W'(upper);
      end
      S_AUS_GO: begin
        div_start    = (allc != '0);
        div_dividend = DIVD_W'(ent.sum_us);
        div_divisor  = allc;
      end
      default: begin
      end
    endcase
  end

  // Record update: bin by the priority chain, then sums and maximum.
  always_comb begin
    logic [2:0]       b;
    logic [SUM_W:0]   s;
    logic [MAX_W-1:0] m28;
    upd = entry_cur;
    if (ms_val >= {1'b0, high_thr}) begin
      b = B_FATAL;
    end else if (ms_val >= {1'b0, normal_thr}) begin
      b = B_HIGH;
    end else if (ms_val >= {1'b0, low_thr}) begin
      b = B_MID;
    end else if (ms_val != '0) begin
      b = B_LOW;
    end else begin
      b = B_MIN;
    end
    if (upd.cnt[b] != '1) begin
      upd.cnt[b] = upd.cnt[b] + CNT_W'(1);
    end
    m28 = ms_val[MS_W-1] ? '1 : ms_val[MAX_W-1:0];
    if (ms_val != '0) begin
      s = {1'b0, entry_cur.sum_ms} + (SUM_W+1)'(ms_val);
      upd.sum_ms = s[SUM_W] ? '1 : s[SUM_W-1:0];
      if (m28 > entry_cur.max_ms) begin
        upd.max_ms = m28;
      end
    end else begin
      s = {1'b0, entry_cur.sum_us} + (SUM_W+1)'(us_val);
      upd.sum_us = s[SUM_W] ? '1 : s[SUM_W-1:0];
    end
  end

  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (rec_go) begin
          state_next = S_CONV;
        end else if (in_fire && (command == CMD_READ)) begin
          state_next = S_RD;
        end
      end
      S_CONV:   if (step == 3'd4) state_next = S_WR;
      S_WR:     state_next = S_IDLE;
      S_RD:     state_next = S_AMS_GO;
      S_AMS_GO: state_next = (upper != '0) ? S_AMS : S_AUS_GO;
      S_AMS:    if (div_done) state_next = S_AUS_GO;
      S_AUS_GO: state_next = (allc != '0) ? S_AUS : S_OUT;
      S_AUS:    if (div_done) state_next = S_OUT;
      S_OUT:    if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      low_thr    <= THR_W'(8);
      normal_thr <= THR_W'(15);
      high_thr   <= THR_W'(30);
      enable     <= 1'b1;
      vld        <= '0;
      evc        <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_fire) begin
        unique case (cfg_index)
          CFG_LOW_MS:    low_thr    <= cfg_data;
          CFG_NORMAL_MS: normal_thr <= cfg_data;
          CFG_HIGH_MS:   high_thr   <= cfg_data;
          CFG_ENABLE:    enable     <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (clear_fire) begin
        vld <= '0;
        evc <= '0;
      end
      if (in_fire && (command == CMD_EVENT) && enable && (event_kind != EV_SLOWPATH)) begin
        if (evc[event_kind] != '1) begin
          evc[event_kind] <= evc[event_kind] + CNT_W'(1);
        end
      end
      if (state == S_WR) begin
        vld[ent_idx] <= 1'b1;
        if (slow && (evc[EV_SLOWPATH] != '1)) begin
          evc[EV_SLOWPATH] <= evc[EV_SLOWPATH] + CNT_W'(1);
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers of the current command.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ent_idx <= in_e;
      rd_ok   <= idx_ok && vld[in_e];
      slow    <= (kind_index == SLOWPATH_KIND);
    end
    if (rec_go) begin
      dly  <= delay_ns;
      step <= '0;
      acc  <= '0;
    end
    // Each step registers one shifted partial product and adds the previous one.
    if (state == S_CONV) begin
      step <= step + 3'd1;
      pp   <= pp_next;
      if (step == 3'd0) begin
        us_val <= us_prod[24 +: US_W];
      end else begin
        acc <= acc + pp;
      end
    end
    if (state == S_RD) begin
      ent   <= entry_cur;
      upper <= (CNT_W+2)'(entry_cur.cnt[B_LOW]) + (CNT_W+2)'(entry_cur.cnt[B_MID])
             + (CNT_W+2)'(entry_cur.cnt[B_HIGH]) + (CNT_W+2)'(entry_cur.cnt[B_FATAL]);
      allc  <= (CNT_W+3)'(entry_cur.cnt[B_MIN]) + (CNT_W+3)'(entry_cur.cnt[B_LOW])
             + (CNT_W+3)'(entry_cur.cnt[B_MID]) + (CNT_W+3)'(entry_cur.cnt[B_HIGH])
             + (CNT_W+3)'(entry_cur.cnt[B_FATAL]);
    end
    if (state == S_AMS_GO) begin
      avg_ms_v <= '0;
    end else if ((state == S_AMS) && div_done) begin
      avg_ms_v <= div_q[SUM_W-1:0];
    end
  end

  // Output register: the result beat waits here until it is taken.
  always_ff @(posedge clk) begin
    if (out_load) begin
      min_count        <= ent.cnt[B_MIN];
      low_count        <= ent.cnt[B_LOW];
      mid_count        <= ent.cnt[B_MID];
      high_count       <= ent.cnt[B_HIGH];
      fatal_count      <= ent.cnt[B_FATAL];
      avg_ms           <= avg_ms_v;
      avg_us           <= (allc != '0) ? div_q[SUM_W-1:0] : '0;
      max_ms           <= ent.max_ms;
      kswapd_count     <= evc[EV_KSWAPD];
      compaction_count <= evc[EV_COMPACT];
      page_alloc_count <= evc[EV_PAGEALLOC];
      slowpath_count   <= evc[EV_SLOWPATH];
    end
  end

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    clear_fire |=> (vld == '0) && (evc == '0))
    else $error("clear left state behind");

  a_valid_drop_by_clear: assert property (@(posedge clk) disable iff (rst)
    (|($past(vld) & ~vld)) |-> $past(clear_fire))
    else $error("entry valid bit dropped without clear");

  a_out_from_out_state: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_OUT))
    else $error("result beat raised outside the output state");

endmodule
`default_nettype wire

### sim/latency_histogram_monitor_unit_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module latency_histogram_monitor_unit_tb;
  import lhm_pkg::*;

  localparam int NGRP = GROUPS_DEF;
  localparam int NKND = KINDS_DEF;
  localparam int NENT = NGRP * NKND;
  localparam logic [47:0] NS_MS = 48'd1000000;
  localparam logic [47:0] NS_US = 48'd1000;
  localparam logic [39:0] SUM_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;
  localparam logic [27:0] THR_MAX = 28'hFFF_FFFF;

  // One expected read beat, laid out like the result ports.
  typedef struct packed {
    logic [31:0] min_c;
    logic [31:0] low_c;
    logic [31:0] mid_c;
    logic [31:0] high_c;
    logic [31:0] fatal_c;
    logic [39:0] avg_ms_v;
    logic [39:0] avg_us_v;
    logic [27:0] max_ms_v;
    logic [31:0] ksw_c;
    logic [31:0] cmp_c;
    logic [31:0] pga_c;
    logic [31:0] slp_c;
  } readout_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [THR_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = '0;
  logic [1:0] group_index = '0;
  logic [1:0] kind_index = '0;
  logic [DELAY_W-1:0] delay_ns = '0;
  logic [1:0] event_kind = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] min_count, low_count, mid_count, high_count, fatal_count;
  logic [39:0] avg_ms, avg_us;
  logic [27:0] max_ms;
  logic [31:0] kswapd_count, compaction_count, page_alloc_count, slowpath_count;

  always #1 clk = ~clk;

  latency_histogram_monitor_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .group_index(group_index), .kind_index(kind_index),
    .delay_ns(delay_ns), .event_kind(event_kind),
    .out_valid(out_valid), .out_ready(out_ready),
    .min_count(min_count), .low_count(low_count), .mid_count(mid_count),
    .high_count(high_count), .fatal_count(fatal_count),
    .avg_ms(avg_ms), .avg_us(avg_us), .max_ms(max_ms),
    .kswapd_count(kswapd_count), .compaction_count(compaction_count),
    .page_alloc_count(page_alloc_count), .slowpath_count(slowpath_count)
  );

  // Shadow copy of the histogram tables and thresholds.
  logic [31:0] hist_cnt [NENT][NBUCKETS];
  logic [39:0] hist_sum_ms [NENT];
  logic [39:0] hist_sum_us [NENT];
  logic [27:0] hist_max [NENT];
  logic [31:0] ev_cnt [NEVENTS];
  logic [27:0] thr_low, thr_normal, thr_high;
  logic monitor_on;

  readout_t pending_reads[$];
  int errors = 0;

  function automatic logic [31:0] sat_inc(input logic [31:0] c);
    return (c == CNT_MAX) ? c : c + 32'd1;
  endfunction

  function automatic logic [39:0] sat_add40(input logic [39:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {9'd0, a} + {1'b0, b};
    return (s > {9'd0, SUM_MAX}) ? SUM_MAX : s[39:0];
  endfunction

  task automatic clear_shadow();
    for (int e = 0; e < NENT; e++) begin
      for (int b = 0; b < NBUCKETS; b++) hist_cnt[e][b] = '0;
      hist_sum_ms[e] = '0;
      hist_sum_us[e] = '0;
      hist_max[e] = '0;
    end
    for (int i = 0; i < NEVENTS; i++) ev_cnt[i] = '0;
  endtask

  // Applies one accepted command beat to the shadow tables and queues
  // the readout beat when the command is a read.
  task automatic apply_command(input logic [1:0] cmd, input logic [1:0] grp,
                               input logic [1:0] knd, input logic [47:0] dly,
                               input logic [1:0] evk);
    logic in_range;
    int e;
    int bk;
    logic [47:0] ms_v, us_v;
    logic [47:0] upper, total;
    readout_t r;
    in_range = (grp < NGRP) && (knd < NKND);
    e = in_range ? grp * NKND + knd : 0;
    ms_v = dly / NS_MS;
    us_v = dly / NS_US;
    case (cmd)
      CMD_RECORD: begin
        if (monitor_on && in_range) begin
          // Priority chain is kept literal so unordered thresholds behave as specified.
          if (ms_v >= thr_high) bk = B_FATAL;
          else if (ms_v >= thr_normal) bk = B_HIGH;
          else if (ms_v >= thr_low) bk = B_MID;
          else if (ms_v >= 1 && ms_v < thr_low) bk = B_LOW;
          else bk = B_MIN;
          hist_cnt[e][bk] = sat_inc(hist_cnt[e][bk]);
          if (ms_v >= 1) begin
            hist_sum_ms[e] = sat_add40(hist_sum_ms[e], ms_v);
            if (((ms_v > THR_MAX) ? THR_MAX : ms_v[27:0]) > hist_max[e])
              hist_max[e] = (ms_v > THR_MAX) ? THR_MAX : ms_v[27:0];
          end else begin
            hist_sum_us[e] = sat_add40(hist_sum_us[e], us_v);
          end
          if (knd == SLOWPATH_KIND) ev_cnt[EV_SLOWPATH] = sat_inc(ev_cnt[EV_SLOWPATH]);
        end
      end
      CMD_EVENT: begin
        if (monitor_on && evk != EV_SLOWPATH) ev_cnt[evk] = sat_inc(ev_cnt[evk]);
      end
      CMD_CLEAR: clear_shadow();
      default: begin
        r = '0;
        if (in_range) begin
          r.min_c = hist_cnt[e][B_MIN];
          r.low_c = hist_cnt[e][B_LOW];
          r.mid_c = hist_cnt[e][B_MID];
          r.high_c = hist_cnt[e][B_HIGH];
          r.fatal_c = hist_cnt[e][B_FATAL];
          upper = 48'(r.low_c) + 48'(r.mid_c) + 48'(r.high_c) + 48'(r.fatal_c);
          total = upper + 48'(r.min_c);
          r.avg_ms_v = (upper != 0) ? 40'(48'(hist_sum_ms[e]) / upper) : '0;
          r.avg_us_v = (total != 0) ? 40'(48'(hist_sum_us[e]) / total) : '0;
          r.max_ms_v = hist_max[e];
        end
        r.ksw_c = ev_cnt[EV_KSWAPD];
        r.cmp_c = ev_cnt[EV_COMPACT];
        r.pga_c = ev_cnt[EV_PAGEALLOC];
        r.slp_c = ev_cnt[EV_SLOWPATH];
        pending_reads.push_back(r);
      end
    endcase
  endtask

  // Sends one command beat after a random gap, holding it until accepted.
  // Valid stays high into the next call so that a zero gap gives back to back beats.
  task automatic send_command(input logic [1:0] cmd, input logic [1:0] grp,
                              input logic [1:0] knd, input logic [47:0] dly,
                              input logic [1:0] evk);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command <= cmd;
    group_index <= grp;
    kind_index <= knd;
    delay_ns <= dly;
    event_kind <= evk;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    apply_command(cmd, grp, knd, dly, evk);
  endtask

  // Waits for all reads to drain plus the block's internal latency, since
  // records finish well after their beat is accepted.
  task automatic wait_idle();
    in_valid <= 1'b0;
    wait (pending_reads.size() == 0);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [27:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LOW_MS: thr_low = val;
      CFG_NORMAL_MS: thr_normal = val;
      CFG_HIGH_MS: thr_high = val;
      default: monitor_on = val[0];
    endcase
  endtask

  task automatic set_thresholds(input logic [27:0] lo, input logic [27:0] nm,
                                input logic [27:0] hi, input logic en);
    wait_idle();
    write_register(CFG_LOW_MS, lo);
    write_register(CFG_NORMAL_MS, nm);
    write_register(CFG_HIGH_MS, hi);
    write_register(CFG_ENABLE, {27'd0, en});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [47:0] rand_delay();
    case ($urandom_range(0, 5))
      0: return 48'($urandom_range(0, 999999));
      1: return 48'($urandom_range(1, 40)) * NS_MS + 48'($urandom_range(0, 999999));
      2: return 48'({$urandom(), $urandom()});
      3: return 48'($urandom_range(0, 2000));
      default: return 48'($urandom_range(0, 60)) * NS_MS + 48'($urandom_range(0, 999999));
    endcase
  endfunction

  // Random mix biased toward records and reads of valid entries.
  task automatic random_traffic(input int count);
    logic [1:0] cmd;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) cmd = CMD_RECORD;
      else if (sel < 70) cmd = CMD_EVENT;
      else if (sel < 98) cmd = CMD_READ;
      else cmd = CMD_CLEAR;
      send_command(cmd,
                   ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, NGRP - 1)),
                   ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, NKND - 1)),
                   rand_delay(), 2'($urandom_range(0, 3)));
    end
  endtask

  task automatic test_directed_bins();
    send_command(CMD_RECORD, 0, 0, 48'd0, 0);
    send_command(CMD_RECORD, 0, 0, 48'd999999, 0);
    send_command(CMD_RECORD, 0, 0, 48'd1000000, 0);
    send_command(CMD_RECORD, 0, 0, 48'd8000000, 0);
    send_command(CMD_RECORD, 0, 0, 48'd15000000, 0);
    send_command(CMD_RECORD, 0, 0, 48'd30000000, 0);
    send_command(CMD_RECORD, 2, 2, '1, 0);
    send_command(CMD_RECORD, 2, 2, 48'd999, 0);
    send_command(CMD_RECORD, 3, 0, 48'd5000000, 0);
    send_command(CMD_RECORD, 0, 3, 48'd5000000, 0);
    for (int k = 0; k < 4; k++) send_command(CMD_EVENT, 0, 0, 0, 2'(k));
    send_command(CMD_READ, 0, 0, 0, 0);
    send_command(CMD_READ, 2, 2, 0, 0);
    send_command(CMD_READ, 3, 3, 0, 0);
    send_command(CMD_READ, 1, 1, 0, 0);
  endtask

  task automatic test_disabled();
    set_thresholds(8, 15, 30, 1'b0);
    send_command(CMD_RECORD, 1, 2, 48'd20000000, 0);
    send_command(CMD_EVENT, 0, 0, 0, EV_KSWAPD);
    send_command(CMD_READ, 1, 2, 0, 0);
    send_command(CMD_CLEAR, 0, 0, 0, 0);
    send_command(CMD_READ, 0, 0, 0, 0);
  endtask

  task automatic test_unordered_thresholds();
    set_thresholds(0, 5, 3, 1'b1);
    send_command(CMD_RECORD, 1, 0, 48'd10, 0);
    send_command(CMD_RECORD, 1, 0, 48'd4000000, 0);
    send_command(CMD_READ, 1, 0, 0, 0);
    set_thresholds(THR_MAX, THR_MAX, THR_MAX, 1'b1);
    send_command(CMD_RECORD, 1, 1, 48'd2000000, 0);
    send_command(CMD_RECORD, 1, 1, '1, 0);
    send_command(CMD_READ, 1, 1, 0, 0);
  endtask

  // Long random phases under several threshold settings, the extremes included.
  task automatic test_random();
    set_thresholds(8, 15, 30, 1'b1);
    random_traffic(200);
    set_thresholds(0, 0, 0, 1'b1);
    random_traffic(60);
    set_thresholds(THR_MAX, THR_MAX, THR_MAX, 1'b1);
    random_traffic(60);
    set_thresholds(2, 10, 25, 1'b1);
    random_traffic(150);
    set_thresholds(5, 20, 40, 1'b0);
    random_traffic(30);
  endtask

  // Result side: random stall per beat, each beat compared field by field.
  initial begin
    int stall;
    readout_t exp_r;
    wait (rst == 1'b0);
    forever begin
      stall = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (pending_reads.size() == 0) begin
        $error("read beat arrived with nothing expected");
        errors++;
      end else begin
        exp_r = pending_reads.pop_front();
        if (min_count !== exp_r.min_c) begin
          $error("min_count exp %0d got %0d", exp_r.min_c, min_count); errors++;
        end
        if (low_count !== exp_r.low_c) begin
          $error("low_count exp %0d got %0d", exp_r.low_c, low_count); errors++;
        end
        if (mid_count !== exp_r.mid_c) begin
          $error("mid_count exp %0d got %0d", exp_r.mid_c, mid_count); errors++;
        end
        if (high_count !== exp_r.high_c) begin
          $error("high_count exp %0d got %0d", exp_r.high_c, high_count); errors++;
        end
        if (fatal_count !== exp_r.fatal_c) begin
          $error("fatal_count exp %0d got %0d", exp_r.fatal_c, fatal_count); errors++;
        end
        if (avg_ms !== exp_r.avg_ms_v) begin
          $error("avg_ms exp %0d got %0d", exp_r.avg_ms_v, avg_ms); errors++;
        end
        if (avg_us !== exp_r.avg_us_v) begin
          $error("avg_us exp %0d got %0d", exp_r.avg_us_v, avg_us); errors++;
        end
        if (max_ms !== exp_r.max_ms_v) begin
          $error("max_ms exp %0d got %0d", exp_r.max_ms_v, max_ms); errors++;
        end
        if (kswapd_count !== exp_r.ksw_c) begin
          $error("kswapd_count exp %0d got %0d", exp_r.ksw_c, kswapd_count); errors++;
        end
        if (compaction_count !== exp_r.cmp_c) begin
          $error("compaction_count exp %0d got %0d", exp_r.cmp_c, compaction_count);
          errors++;
        end
        if (page_alloc_count !== exp_r.pga_c) begin
          $error("page_alloc_count exp %0d got %0d", exp_r.pga_c, page_alloc_count);
          errors++;
        end
        if (slowpath_count !== exp_r.slp_c) begin
          $error("slowpath_count exp %0d got %0d", exp_r.slp_c, slowpath_count);
          errors++;
        end
      end
    end
  end

  // Watchdog: several times the slowest legal run of about 500 commands.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    clear_shadow();
    thr_low = 8;
    thr_normal = 15;
    thr_high = 30;
    monitor_on = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_bins();
    test_disabled();
    test_unordered_thresholds();
    test_random();
    wait_idle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
design/lhm_pkg.sv
design/lhm_ram.sv
design/lhm_div.sv
design/latency_histogram_monitor_unit.sv
sim/latency_histogram_monitor_unit_tb.sv
